[hw/rtl/rfs_pkg.sv]
// ----------------------------------------------------------------------------
// rfs_pkg: ring FIFO with search, shared types and constants
// Request and response payload structs, request and status codes, and the
// default sizes handed to the top-level parameters.
// ----------------------------------------------------------------------------
package rfs_pkg;

	// Default sizes
	localparam int DEPTH_DEF       = 16;
	localparam int ENTRY_WIDTH_DEF = 32;

	// Fixed field widths of the request and response payloads
	localparam int REQ_W  = 2;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 4;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [DATA_W-1:0] entry_data;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] out_data;
		logic [POS_W-1:0]  match_position;
		logic              is_empty;
		logic [CNT_W-1:0]  used_count;
	} rsp_t;

endpackage

[hw/rtl/rfs_mem.sv]
// ----------------------------------------------------------------------------
// rfs_mem: entry storage
// One write port and one read port, read data registered. Contents are not
// reset; a slot's read data is only used after the slot was written.
// ----------------------------------------------------------------------------
module rfs_mem #(
	parameter int DEPTH       = 16,
	parameter int ENTRY_WIDTH = 32,
	localparam int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [IW-1:0]          waddr,
	input  logic [ENTRY_WIDTH-1:0] wdata,
	input  logic [IW-1:0]          raddr,
	output logic [ENTRY_WIDTH-1:0] rdata
);

	logic [ENTRY_WIDTH-1:0] mem_q [DEPTH];
	logic [ENTRY_WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/rfs_seq.sv]
// ----------------------------------------------------------------------------
// rfs_seq: request sequencer and scan compare unit
// Holds head and tail, drives the storage ports, walks stored entries one read
// per cycle through a single comparator, and holds the response register.
// ----------------------------------------------------------------------------
module rfs_seq #(
	parameter int DEPTH       = 16,
	parameter int ENTRY_WIDTH = 32,
	localparam int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  rfs_pkg::req_t          req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rfs_pkg::rsp_t          rsp_data,
	output logic                   mem_we,
	output logic [IW-1:0]          mem_waddr,
	output logic [ENTRY_WIDTH-1:0] mem_wdata,
	output logic [IW-1:0]          mem_raddr,
	input  logic [ENTRY_WIDTH-1:0] mem_rdata
);

	import rfs_pkg::*;

	// Helper widths for explicit extend-or-truncate
	localparam int KW = (ENTRY_WIDTH > DATA_W) ? ENTRY_WIDTH : DATA_W;
	localparam int PW = (IW > POS_W) ? IW : POS_W;
	localparam int UW = IW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_RD,
		S_SCAN,
		S_RESP
	} state_t;

	state_t                 state_q;
	logic [IW-1:0]          head_q;
	logic [IW-1:0]          tail_q;
	logic [IW-1:0]          iss_q;
	logic                   rd_vld_q;
	logic [IW-1:0]          dist_q;
	logic [ENTRY_WIDTH-1:0] key_q;
	logic [STAT_W-1:0]      res_status_q;
	logic [DATA_W-1:0]      res_data_q;
	logic [POS_W-1:0]       res_pos_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   accept;
	logic [IW-1:0]          tail_nxt;
	logic [IW-1:0]          head_nxt;
	logic [IW-1:0]          iss_nxt;
	logic                   full;
	logic                   empty;
	logic [KW-1:0]          key_ext;
	logic [ENTRY_WIDTH-1:0] key;
	logic [KW-1:0]          rdata_ext;
	logic [DATA_W-1:0]      rdata_out;
	logic [PW-1:0]          dist_ext;
	logic [UW-1:0]          used_wide;
	logic [PW-1:0]          used_ext;
	logic                   hit;
	logic                   rsp_free;

	// Index wrap
	assign tail_nxt = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign head_nxt = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign iss_nxt  = (iss_q == LAST_IDX) ? '0 : iss_q + 1'b1;

	assign full  = (tail_nxt == head_q);
	assign empty = (head_q == tail_q);

	// Entry masking both ways
	assign key_ext   = KW'(req_data.entry_data);
	assign key       = key_ext[ENTRY_WIDTH-1:0];
	assign rdata_ext = KW'(mem_rdata);
	assign rdata_out = rdata_ext[DATA_W-1:0];

	// Occupancy from head and tail
	always_comb begin
		if (tail_q >= head_q) begin
			used_wide = UW'(tail_q) - UW'(head_q);
		end else begin
			used_wide = UW'(DEPTH) - UW'(head_q) + UW'(tail_q);
		end
	end
	assign used_ext = PW'(used_wide[IW-1:0]);
	assign dist_ext = PW'(dist_q);

	// Shared comparator
	assign hit = (mem_rdata == key_q);

	// Handshake
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Storage ports
	assign mem_we    = accept && (req_data.req_type == REQ_PUSH) && !full;
	assign mem_waddr = tail_q;
	assign mem_wdata = key;
	assign mem_raddr = (state_q == S_SCAN) ? iss_q : head_q;

	// Sequencer, pointers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			iss_q        <= '0;
			rd_vld_q     <= 1'b0;
			dist_q       <= '0;
			key_q        <= '0;
			res_status_q <= ST_OK;
			res_data_q   <= '0;
			res_pos_q    <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// response register: load when finished, drop once taken
			if ((state_q == S_RESP) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_data_q <= '0;
						res_pos_q  <= '0;
						case (req_data.req_type)
							REQ_PUSH: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_OK;
									tail_q       <= tail_nxt;
								end
								state_q <= S_RESP;
							end
							REQ_POP: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ST_OK;
									head_q       <= head_nxt;
									state_q      <= S_POP_RD;
								end
							end
							REQ_SEARCH: begin
								res_status_q <= ST_OK;
								key_q        <= key;
								iss_q        <= head_q;
								rd_vld_q     <= 1'b0;
								dist_q       <= '0;
								state_q      <= S_SCAN;
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_POP_RD: begin
					res_data_q <= rdata_out;
					state_q    <= S_RESP;
				end
				S_SCAN: begin
					// issue one read a cycle, compare the one from the cycle before
					if (iss_q != tail_q) begin
						iss_q    <= iss_nxt;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
					end
					if (rd_vld_q) begin
						if (hit) begin
							res_pos_q <= dist_ext[POS_W-1:0];
							state_q   <= S_RESP;
						end else begin
							dist_q <= dist_q + 1'b1;
						end
					end else if (iss_q == tail_q) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.status         <= res_status_q;
						rsp_q.out_data       <= res_data_q;
						rsp_q.match_position <= res_pos_q;
						rsp_q.is_empty       <= empty;
						rsp_q.used_count     <= used_ext[CNT_W-1:0];
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ring_fifo_with_search_top.sv]
// ----------------------------------------------------------------------------
// ring_fifo_with_search_top: ring FIFO with linear search
// Circular FIFO of DEPTH slots (DEPTH-1 usable) that serves push, pop and
// search requests, one request at a time, with one response per request.
//
//   channel  | signals                        | payload
//   ---------+--------------------------------+-----------------------------
//   request  | req_valid, req_stall, req_data | req_type, entry_data
//   response | rsp_valid, rsp_stall, rsp_data | status, out_data,
//            |                                | match_position, is_empty,
//            |                                | used_count
//
// Pop goes through an extra read state before its response (registered storage read).
// Search walks the stored entries oldest first: the scan issues
// one storage read per cycle and feeds one comparator.
// Reset clears head, tail and control; storage contents are not cleared.
// The request side is stalled while a request is in progress; a finished
// response sits in the output register until taken.
// ----------------------------------------------------------------------------
module ring_fifo_with_search_top #(
	parameter int DEPTH       = rfs_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = rfs_pkg::ENTRY_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rfs_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rfs_pkg::rsp_t rsp_data
);

	import rfs_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [ENTRY_WIDTH-1:0] mem_wdata;
	logic [IW-1:0]          mem_raddr;
	logic [ENTRY_WIDTH-1:0] mem_rdata;

	// Sequencer and compare unit
	rfs_seq #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry storage
	rfs_mem #(
		.DEPTH       (DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ring FIFO with search
// Sends push, pop, search and no-op requests into the block while both
// channels idle at random. A shadow FIFO predicts every response, and each
// accepted response is compared field by field, in request order.
// ----------------------------------------------------------------------------
module testbench;
	import rfs_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int ENTRY_W      = ENTRY_WIDTH_DEF;
	localparam int RAND_ITEMS   = 1650;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_W);

	// Shadow FIFO: predicts responses and checks them in order
	class ring_fifo_shadow;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned head = 0;
		int unsigned tail = 0;
		rsp_t pending_rsps [$];
		int unsigned errors = 0;

		function int unsigned held();
			return (tail >= head) ? tail - head : DEPTH - head + tail;
		endfunction

		// k-th entry counted from the oldest
		function logic [DATA_W-1:0] held_entry(int unsigned k);
			return slots[(head + k) % DEPTH];
		endfunction

		function void take_request(req_t r);
			logic [DATA_W-1:0] value;
			int unsigned scan;
			int unsigned offset;
			rsp_t e;
			value = r.entry_data & ENTRY_MASK;
			e = '0;
			case (r.req_type)
				REQ_PUSH: begin
					if ((tail + 1) % DEPTH == head) begin
						e.status = ST_FULL;
					end else begin
						slots[tail] = value;
						tail = (tail + 1) % DEPTH;
					end
				end
				REQ_POP: begin
					if (head == tail) begin
						e.status = ST_EMPTY;
					end else begin
						e.out_data = slots[head];
						head = (head + 1) % DEPTH;
					end
				end
				REQ_SEARCH: begin
					// walk oldest to newest, stop at first match
					e.status = ST_NOT_FOUND;
					scan = head;
					offset = 0;
					while (scan != tail && e.status == ST_NOT_FOUND) begin
						if (slots[scan] == value) begin
							e.status = ST_OK;
							e.match_position = POS_W'(offset);
						end else begin
							scan = (scan + 1) % DEPTH;
							offset++;
						end
					end
				end
				default: ;
			endcase
			e.is_empty = (head == tail);
			e.used_count = CNT_W'(held());
			pending_rsps.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsps.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_rsps.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.out_data !== want.out_data) begin
				$error("out_data: expected %h, actual %h", want.out_data, got.out_data);
				errors++;
			end
			if (got.match_position !== want.match_position) begin
				$error("match_position: expected %0d, actual %0d",
					want.match_position, got.match_position);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
				errors++;
			end
			if (got.used_count !== want.used_count) begin
				$error("used_count: expected %0d, actual %0d",
					want.used_count, got.used_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	int unsigned send_idle_pct = 34;
	int unsigned stall_pct = 81;
	logic hold = 1'b0;
	int phase = 0;
	ring_fifo_shadow shadow = new;

	ring_fifo_with_search_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// Clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Response side stall: random, or held during the pressure window
	always @(posedge clk) begin
		rsp_stall <= hold || ($urandom_range(99) < stall_pct);
	end

	// Pressure: long receiver hold-off while requests keep coming
	initial begin
		wait (phase == 2);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	// Response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			shadow.check_response(rsp_data);
		end
	end

	// One request: optional idle gap, then hold until accepted
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{req_type: kind, entry_data: value};
		do @(posedge clk); while (req_stall !== 1'b0);
		shadow.take_request(req_data);
	endtask

	// Entry values: small pool for repeats, values near all-ones, full range
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return DATA_W'($urandom_range(7));
			1: return ~DATA_W'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request(input int unsigned push_pct);
		int unsigned roll;
		int unsigned n;
		roll = $urandom_range(99);
		n = shadow.held();
		if (roll < 3) begin
			send_req(REQ_NOP, $urandom);
		end else if (roll < 28) begin
			// mostly hits on held entries, else arbitrary values
			if (n != 0 && $urandom_range(9) < 7) begin
				send_req(REQ_SEARCH, shadow.held_entry($urandom_range(n - 1)));
			end else begin
				send_req(REQ_SEARCH, pick_value());
			end
		end else if ($urandom_range(99) < push_pct) begin
			send_req(REQ_PUSH, pick_value());
		end else begin
			send_req(REQ_POP, $urandom);
		end
	endtask

	// Main sequence
	initial begin
		int unsigned push_pct;
		logic [DATA_W-1:0] fill;
		push_pct = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, no-op, fill to full, searches, pops
		send_req(REQ_POP, 32'hFFFF_FFFF);
		send_req(REQ_SEARCH, 32'h0);
		send_req(REQ_NOP, 32'h5555_AAAA);
		for (int k = 0; k < DEPTH - 1; k++) begin
			if (k == 0)
				fill = 32'h0;
			else if (k == DEPTH - 2)
				fill = 32'hFFFF_FFFF;
			else if (k == 5 || k == 9)
				fill = 32'hA5A5_5A5A;
			else
				fill = k * 32'h1111_1111;
			send_req(REQ_PUSH, fill);
		end
		send_req(REQ_PUSH, 32'h1234_5678);
		send_req(REQ_SEARCH, 32'hFFFF_FFFF);
		send_req(REQ_SEARCH, 32'h0);
		send_req(REQ_SEARCH, 32'hA5A5_5A5A);
		send_req(REQ_SEARCH, 32'hDEAD_BEEF);
		send_req(REQ_POP, 32'h0);
		send_req(REQ_POP, 32'h0);

		// random: three idling phases, push bias drifting every few dozen
		for (int p = 0; p < 3; p++) begin
			phase = p;
			case (p)
				0: begin
					send_idle_pct = 34;
					stall_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					stall_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int i = 0; i < RAND_ITEMS / 3; i++) begin
				if (i % 48 == 0)
					push_pct = $urandom_range(85, 15);
				random_request(push_pct);
			end
		end
		req_valid <= 1'b0;

		while (shadow.pending_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending_rsps.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/rfs_pkg.sv
hw/rtl/rfs_mem.sv
hw/rtl/rfs_seq.sv
hw/rtl/ring_fifo_with_search_top.sv
tb/sv/testbench.sv
